@@ rtl/tbc_pkg.sv @@
package tbc_pkg;

  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CAM_X = 2'd0,
    CFG_CAM_Y = 2'd1,
    CFG_CAM_Z = 2'd2
  } tbc_cfg_idx_t;

  // poly_flags bit positions
  localparam int FLAG_ACTIVE   = 0;
  localparam int FLAG_CLIPPED  = 1;
  localparam int FLAG_BACKFACE = 2;
  localparam int FLAG_BITS     = 3;

  typedef struct packed {
    logic tested;
    logic prior;
    logic last;
  } tbc_ctl_t;

  localparam int CTL_W = $bits(tbc_ctl_t);

endpackage

@@ rtl/tbc_if.sv @@
interface tbc_in_if import tbc_pkg::*; #(
  parameter int COORD_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] vertex0_x;
  logic [COORD_BITS-1:0] vertex0_y;
  logic [COORD_BITS-1:0] vertex0_z;
  logic [COORD_BITS-1:0] vertex1_x;
  logic [COORD_BITS-1:0] vertex1_y;
  logic [COORD_BITS-1:0] vertex1_z;
  logic [COORD_BITS-1:0] vertex2_x;
  logic [COORD_BITS-1:0] vertex2_y;
  logic [COORD_BITS-1:0] vertex2_z;
  logic [FLAG_BITS-1:0]  poly_flags;
  logic                  two_sided;
  logic                  last_poly;

  modport source (
    output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
           vertex2_x, vertex2_y, vertex2_z, poly_flags, two_sided, last_poly,
    input  ready
  );
  modport sink (
    input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
           vertex2_x, vertex2_y, vertex2_z, poly_flags, two_sided, last_poly,
    output ready
  );
endinterface

interface tbc_out_if;
  logic valid;
  logic ready;
  logic backface;
  logic tested;
  logic last_out;

  modport source (output valid, backface, tested, last_out, input ready);
  modport sink   (input valid, backface, tested, last_out, output ready);
endinterface

interface tbc_cfg_if import tbc_pkg::*; #(
  parameter int COORD_BITS = 24
);
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COORD_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/tbc_front.sv @@
module tbc_front import tbc_pkg::*; #(
  parameter int COORD_BITS = 24,
  localparam int DW = COORD_BITS + 1,
  localparam int DATA_W = 9 * DW
) (
  input  logic              clk,
  input  logic              rst_n,
  tbc_in_if.sink            in_tri,
  tbc_cfg_if.sink           cfg_wr,
  output logic              fr_valid,
  input  logic              fr_ready,
  output logic [DATA_W-1:0] fr_data,
  output tbc_ctl_t          fr_ctl
);

  logic [COORD_BITS-1:0] cam_r [3];
  logic                  fr_valid_r;
  logic [DATA_W-1:0]     fr_data_r;
  tbc_ctl_t              fr_ctl_r;
  tbc_ctl_t              ctl_nxt;
  logic                  take;

  function automatic logic [DW-1:0] sdiff(logic [COORD_BITS-1:0] a,
                                          logic [COORD_BITS-1:0] b);
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r[0] <= '0;
      cam_r[1] <= '0;
      cam_r[2] <= '0;
    end else if (cfg_wr.valid) begin
      case (tbc_cfg_idx_t'(cfg_wr.index))
        CFG_CAM_X: cam_r[0] <= cfg_wr.data;
        CFG_CAM_Y: cam_r[1] <= cfg_wr.data;
        CFG_CAM_Z: cam_r[2] <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign in_tri.ready = !fr_valid_r || fr_ready;
  assign take         = in_tri.valid && in_tri.ready;

  always_comb begin
    ctl_nxt.prior  = in_tri.poly_flags[FLAG_BACKFACE];
    ctl_nxt.tested = in_tri.poly_flags[FLAG_ACTIVE] && !in_tri.poly_flags[FLAG_CLIPPED] &&
                     !in_tri.two_sided && !in_tri.poly_flags[FLAG_BACKFACE];
    ctl_nxt.last   = in_tri.last_poly;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_tri.ready) begin
      fr_valid_r <= in_tri.valid;
    end
  end

  // edge vectors u = v1 - v0, w = v2 - v0 and view = cam - v0
  always_ff @(posedge clk) begin
    if (take) begin
      fr_ctl_r  <= ctl_nxt;
      fr_data_r <= {sdiff(in_tri.vertex1_x, in_tri.vertex0_x),
                    sdiff(in_tri.vertex1_y, in_tri.vertex0_y),
                    sdiff(in_tri.vertex1_z, in_tri.vertex0_z),
                    sdiff(in_tri.vertex2_x, in_tri.vertex0_x),
                    sdiff(in_tri.vertex2_y, in_tri.vertex0_y),
                    sdiff(in_tri.vertex2_z, in_tri.vertex0_z),
                    sdiff(cam_r[0], in_tri.vertex0_x),
                    sdiff(cam_r[1], in_tri.vertex0_y),
                    sdiff(cam_r[2], in_tri.vertex0_z)};
    end
  end

  assign fr_valid = fr_valid_r;
  assign fr_data  = fr_data_r;
  assign fr_ctl   = fr_ctl_r;

endmodule

@@ rtl/tbc_fifo.sv @@
module tbc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign wr_ready = count_r != CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

@@ rtl/tbc_back.sv @@
module tbc_back import tbc_pkg::*; #(
  parameter int COORD_BITS = 24,
  localparam int DW = COORD_BITS + 1,
  localparam int DATA_W = 9 * DW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic [DATA_W-1:0] q_data,
  input  tbc_ctl_t          q_ctl,
  tbc_out_if.source         out_res
);

  localparam int PW  = 2 * COORD_BITS + 2;   // edge cross term
  localparam int NW  = PW + 1;               // normal component
  localparam int KW  = COORD_BITS + 2;       // low slice of the normal
  localparam int HW  = NW - KW;              // signed high slice
  localparam int LPW = KW + 1 + DW;
  localparam int HPW = HW + DW;
  localparam int TW  = 3 * COORD_BITS + 6;   // dot product

  localparam int NSTG = 5;

  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] w [3];
  logic signed [DW-1:0] vw [3];

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;

  logic signed [PW-1:0]  p_r [6];
  logic signed [DW-1:0]  view1_r [3];
  logic signed [NW-1:0]  n_r [3];
  logic signed [DW-1:0]  view2_r [3];
  logic signed [HPW-1:0] hp_r [3];
  logic signed [LPW-1:0] lp_r [3];
  logic signed [TW-1:0]  t_r [3];
  tbc_ctl_t              ctl_r [NSTG-1];
  logic signed [TW-1:0]  dot;
  logic                  facing_away;
  logic                  backface_r, tested_r, last_r;

  for (genvar j = 0; j < 3; j++) begin : g_unpack
    assign u[j]  = $signed(q_data[DATA_W-1 - j*DW -: DW]);
    assign w[j]  = $signed(q_data[DATA_W-1 - (j+3)*DW -: DW]);
    assign vw[j] = $signed(q_data[DATA_W-1 - (j+6)*DW -: DW]);
  end

  // per-stage ready: a stage loads when empty or when its content moves on
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_res.ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && q_valid;
    for (int k = 1; k < NSTG; k++) begin
      ld[k] = rdy[k] && vld_r[k-1];
    end
  end

  assign q_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= q_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // control flags travel alongside the datapath stages
  always_ff @(posedge clk) begin
    if (ld[0]) ctl_r[0] <= q_ctl;
    for (int k = 1; k < NSTG-1; k++) begin
      if (ld[k]) ctl_r[k] <= ctl_r[k-1];
    end
  end

  // stage 1: cross terms of u x w
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p_r[0]   <= u[1] * w[2];
      p_r[1]   <= u[2] * w[1];
      p_r[2]   <= u[2] * w[0];
      p_r[3]   <= u[0] * w[2];
      p_r[4]   <= u[0] * w[1];
      p_r[5]   <= u[1] * w[0];
      view1_r  <= vw;
    end
  end

  // stage 2: normal
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= {p_r[2*i][PW-1], p_r[2*i]} - {p_r[2*i+1][PW-1], p_r[2*i+1]};
      end
      view2_r  <= view1_r;
    end
  end

  // stage 3: n * view split into high and low partial products
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        hp_r[i] <= $signed(n_r[i][NW-1:KW]) * view2_r[i];
        lp_r[i] <= $signed({1'b0, n_r[i][KW-1:0]}) * view2_r[i];
      end
    end
  end

  // stage 4: recombine each component
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int i = 0; i < 3; i++) begin
        t_r[i] <= ({{(TW-HPW){hp_r[i][HPW-1]}}, hp_r[i]} << KW) +
                  {{(TW-LPW){lp_r[i][LPW-1]}}, lp_r[i]};
      end
    end
  end

  // stage 5: dot product sign, output register
  assign dot         = t_r[0] + t_r[1] + t_r[2];
  assign facing_away = dot[TW-1] || (dot == '0);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      backface_r <= ctl_r[3].prior || (ctl_r[3].tested && facing_away);
      tested_r   <= ctl_r[3].tested;
      last_r     <= ctl_r[3].last;
    end
  end

  assign out_res.valid    = vld_r[NSTG-1];
  assign out_res.backface = backface_r;
  assign out_res.tested   = tested_r;
  assign out_res.last_out = last_r;

endmodule

@@ rtl/triangle_backface_cull.sv @@
// A triangle passes the front register, the 2-entry queue and the five back-end
// stages in turn. Throughput: one triangle per cycle while the output is not
// stalled; these buffers let the front keep accepting under a stall until all are full.
// Reset: synchronous, active low; clears all valid flags, queue pointers and
// the camera registers (to 0). Datapath registers are not reset.
module triangle_backface_cull import tbc_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  tbc_in_if.sink    in_tri,
  tbc_cfg_if.sink   cfg_wr,
  tbc_out_if.source out_res
);

  localparam int DW     = COORD_BITS + 1;
  localparam int DATA_W = 9 * DW;
  localparam int ITEM_W = DATA_W + CTL_W;

  logic              fr_valid, fr_ready;
  logic [DATA_W-1:0] fr_data;
  tbc_ctl_t          fr_ctl;
  logic              q_valid, q_ready;
  logic [ITEM_W-1:0] q_item;

  tbc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tri   (in_tri),
    .cfg_wr   (cfg_wr),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_data  (fr_data),
    .fr_ctl   (fr_ctl)
  );

  tbc_fifo #(.WIDTH(ITEM_W), .DEPTH(2)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  ({fr_ctl, fr_data}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_item)
  );

  tbc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_item[DATA_W-1:0]),
    .q_ctl   (tbc_ctl_t'(q_item[ITEM_W-1:DATA_W])),
    .out_res (out_res)
  );

endmodule

@@ rtl/tbc_checker.sv @@
module tbc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_backface,
  input logic out_tested,
  input logic out_last
);

  logic [3:0] pending_r;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_beat && !out_beat) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_beat && !in_beat) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result beat without an accepted triangle");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == '0 |-> in_ready)
    else $error("input stalled while block is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_backface) && $stable(out_tested) && $stable(out_last))
    else $error("stalled result beat changed");

endmodule

bind triangle_backface_cull tbc_checker u_tbc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_tri.valid),
  .in_ready     (in_tri.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .out_backface (out_res.backface),
  .out_tested   (out_res.tested),
  .out_last     (out_res.last_out)
);

@@ tb/sv/tb_top.sv @@
module tb_top;
  import tbc_pkg::*;

  localparam int CB   = 24;
  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;

  localparam logic [FLAG_BITS-1:0] F_ACT  = 3'(1 << FLAG_ACTIVE);
  localparam logic [FLAG_BITS-1:0] F_CLIP = 3'(1 << FLAG_CLIPPED);
  localparam logic [FLAG_BITS-1:0] F_BACK = 3'(1 << FLAG_BACKFACE);

  // index past cam_z, writes to it must be dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [CB-1:0]        c[9];  // v0 xyz, v1 xyz, v2 xyz
    logic [FLAG_BITS-1:0] flags;
    logic                 two_sided;
    logic                 last;
  } tri_t;

  typedef struct packed {
    logic backface;
    logic tested;
    logic last_out;
  } verdict_t;

  typedef struct {
    tri_t     t;
    bit       known;
    verdict_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  tbc_in_if  #(.COORD_BITS(CB)) tri_if ();
  tbc_cfg_if #(.COORD_BITS(CB)) cfg_if ();
  tbc_out_if                    res_if ();

  triangle_backface_cull #(.COORD_BITS(CB)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tri  (tri_if),
    .cfg_wr  (cfg_if),
    .out_res (res_if)
  );

  logic [CB-1:0] cam_now[3];
  verdict_t      pending_verdicts[$];
  dir_row_t      dir_rows[$];
  int            mis_count = 0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("triangle_backface_cull regression: fail");
    $finish;
  end

  // exact facing test on sign-extended coordinates; 128 bits never overflow
  function automatic verdict_t facing_verdict(input tri_t t);
    logic signed [127:0] p0[3], p1[3], p2[3], u[3], w[3], vw[3], n[3];
    logic signed [127:0] dot;
    verdict_t            r;
    int                  i;
    r.tested   = t.flags[FLAG_ACTIVE] && !t.flags[FLAG_CLIPPED] && !t.two_sided &&
                 !t.flags[FLAG_BACKFACE];
    r.backface = t.flags[FLAG_BACKFACE];
    r.last_out = t.last;
    if (r.tested) begin
      for (i = 0; i < 3; i++) begin
        p0[i] = $signed(t.c[i]);
        p1[i] = $signed(t.c[3 + i]);
        p2[i] = $signed(t.c[6 + i]);
        u[i]  = p1[i] - p0[i];
        w[i]  = p2[i] - p0[i];
        vw[i] = $signed(cam_now[i]);
        vw[i] = vw[i] - p0[i];
      end
      n[0] = u[1] * w[2] - u[2] * w[1];
      n[1] = u[2] * w[0] - u[0] * w[2];
      n[2] = u[0] * w[1] - u[1] * w[0];
      dot  = n[0] * vw[0] + n[1] * vw[1] + n[2] * vw[2];
      if (dot <= 0) r.backface = 1'b1;
    end
    return r;
  endfunction

  task automatic add_row(input int x0, y0, z0, x1, y1, z1, x2, y2, z2,
                         input logic [FLAG_BITS-1:0] fl, input bit ts, lp,
                         input bit known, bf, tst);
    dir_row_t row;
    row.t.c[0] = CB'(x0); row.t.c[1] = CB'(y0); row.t.c[2] = CB'(z0);
    row.t.c[3] = CB'(x1); row.t.c[4] = CB'(y1); row.t.c[5] = CB'(z1);
    row.t.c[6] = CB'(x2); row.t.c[7] = CB'(y2); row.t.c[8] = CB'(z2);
    row.t.flags     = fl;
    row.t.two_sided = ts;
    row.t.last      = lp;
    row.known       = known;
    row.want        = '{backface: bf, tested: tst, last_out: lp};
    dir_rows.push_back(row);
  endtask

  function automatic tri_t gen_tri();
    tri_t t;
    int   kind, shape, k, v;
    int   base[3], step[3];
    kind = $urandom_range(99);
    if (kind < 70) begin
      t.flags     = F_ACT;
      t.two_sided = 1'b0;
    end else begin
      t.flags     = 3'($urandom());
      t.two_sided = 1'($urandom());
    end
    t.last = ($urandom_range(7) == 0);
    shape = $urandom_range(99);
    if (shape < 40) begin
      foreach (t.c[k]) t.c[k] = CB'($urandom());
    end else if (shape < 75) begin
      // small triangle somewhere near the origin
      for (k = 0; k < 3; k++) base[k] = int'($urandom_range(8191)) - 4096;
      for (v = 0; v < 3; v++)
        for (k = 0; k < 3; k++)
          t.c[3 * v + k] = CB'(base[k] + ((v == 0) ? 0 : int'($urandom_range(511)) - 256));
    end else if (shape < 85) begin
      foreach (t.c[k]) begin
        case ($urandom_range(5))
          0:       t.c[k] = CB'(MINC);
          1:       t.c[k] = CB'(MAXC);
          2:       t.c[k] = '0;
          3:       t.c[k] = '1;
          4:       t.c[k] = CB'(1);
          default: t.c[k] = CB'($urandom());
        endcase
      end
    end else if (shape < 92) begin
      // collinear, or fully degenerate when the step is zero
      for (k = 0; k < 3; k++) begin
        base[k] = int'($urandom_range(1048575)) - 524288;
        step[k] = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(4095)) - 2048;
      end
      for (v = 0; v < 3; v++)
        for (k = 0; k < 3; k++) t.c[3 * v + k] = CB'(base[k] + v * step[k]);
    end else begin
      // first vertex sits on the camera
      foreach (t.c[k]) t.c[k] = (k < 3) ? cam_now[k] : CB'($urandom());
    end
    return t;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mis_count++;
  endtask

  task automatic push_tri(input tri_t t, input verdict_t v);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      tri_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    tri_if.valid      <= 1'b1;
    tri_if.vertex0_x  <= t.c[0];
    tri_if.vertex0_y  <= t.c[1];
    tri_if.vertex0_z  <= t.c[2];
    tri_if.vertex1_x  <= t.c[3];
    tri_if.vertex1_y  <= t.c[4];
    tri_if.vertex1_z  <= t.c[5];
    tri_if.vertex2_x  <= t.c[6];
    tri_if.vertex2_y  <= t.c[7];
    tri_if.vertex2_z  <= t.c[8];
    tri_if.poly_flags <= t.flags;
    tri_if.two_sided  <= t.two_sided;
    tri_if.last_poly  <= t.last;
    @(posedge clk);
    while (!tri_if.ready) @(posedge clk);
    pending_verdicts.push_back(v);
  endtask

  task automatic drain();
    tri_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // burst of register writes, valid held high across the beats
  task automatic load_camera(input logic [CB-1:0] cx, cy, cz, input bit spare);
    logic [CFG_IDX_BITS-1:0] slot[$];
    logic [CB-1:0]           val[$];
    slot = '{CFG_CAM_X, CFG_CAM_Y, CFG_CAM_Z};
    val  = '{cx, cy, cz};
    if (spare) begin
      slot.push_back(CFG_SPARE);
      val.push_back(CB'($urandom()));
    end
    foreach (slot[k]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= slot[k];
      cfg_if.data  <= val[k];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      if (slot[k] != CFG_SPARE) cam_now[slot[k]] = val[k];
    end
    cfg_if.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    res_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        report("result beat with no triangle pending");
      end else begin
        want = pending_verdicts.pop_front();
        if (res_if.backface !== want.backface)
          report($sformatf("backface got %b want %b", res_if.backface, want.backface));
        if (res_if.tested !== want.tested)
          report($sformatf("tested got %b want %b", res_if.tested, want.tested));
        if (res_if.last_out !== want.last_out)
          report($sformatf("last_out got %b want %b", res_if.last_out, want.last_out));
      end
    end
  end

  initial begin
    tri_t    t;
    logic [CB-1:0] cx, cy, cz;
    int      p, k;

    rst_n             <= 1'b0;
    tri_if.valid      <= 1'b0;
    tri_if.vertex0_x  <= '0;
    tri_if.vertex0_y  <= '0;
    tri_if.vertex0_z  <= '0;
    tri_if.vertex1_x  <= '0;
    tri_if.vertex1_y  <= '0;
    tri_if.vertex1_z  <= '0;
    tri_if.vertex2_x  <= '0;
    tri_if.vertex2_y  <= '0;
    tri_if.vertex2_z  <= '0;
    tri_if.poly_flags <= '0;
    tri_if.two_sided  <= 1'b0;
    tri_if.last_poly  <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CFG_CAM_X;
    cfg_if.data       <= '0;
    foreach (cam_now[k]) cam_now[k] = '0;

    // untested triangles, facing cases, degenerate and extreme geometry
    //      v0                  v1                  v2                 flags  ts lp  k bf ts
    add_row(1, 2, 3,            4, 5, 6,            7, 8, 9,            3'b0,   0, 0, 1, 0, 0);
    add_row(1, 2, 3,            4, 5, 6,            7, 8, 9,     F_ACT|F_CLIP,  0, 0, 1, 0, 0);
    add_row(0, 0, -256,         256, 0, -256,       0, 256, -256, F_ACT|F_BACK, 0, 0, 1, 1, 0);
    add_row(0, 0, -256,         0, 256, -256,       256, 0, -256,  F_ACT,       1, 1, 1, 0, 0);
    add_row(5, 6, 7,            8, 9, 10,           11, 12, 13,    F_BACK,      1, 0, 1, 1, 0);
    add_row(MAXC, 0, MINC,      0, MAXC, 0,         MINC, 0, MAXC, 3'b111,      1, 1, 1, 1, 0);
    add_row(5, 6, 7,            8, 9, 10,           11, 12, 13,  F_CLIP|F_BACK, 0, 0, 1, 1, 0);
    add_row(0, 0, -256,         256, 0, -256,       0, 256, -256,  F_ACT,       0, 0, 1, 0, 1);
    add_row(0, 0, -256,         0, 256, -256,       256, 0, -256,  F_ACT,       0, 1, 1, 1, 1);
    add_row(MAXC, MAXC, MAXC,   MAXC, MAXC, MAXC,   MAXC, MAXC, MAXC, F_ACT,    0, 0, 1, 1, 1);
    add_row(0, 0, 0,            256, 256, 256,      512, 512, 512, F_ACT,       0, 0, 1, 1, 1);
    add_row(256, 0, 0,          0, 256, 0,          -256, -256, 0, F_ACT,       0, 0, 1, 1, 1);
    add_row(0, 0, 0,            MAXC, 0, 0,         0, MAXC, 0,    F_ACT,       0, 1, 1, 1, 1);
    add_row(MINC, MINC, MINC,   MAXC, MINC, MINC,   MINC, MAXC, MINC, F_ACT,    0, 0, 0, 0, 0);
    add_row(MAXC, MAXC, MAXC,   MINC, MAXC, MAXC,   MAXC, MINC, MAXC, F_ACT,    0, 0, 0, 0, 0);
    add_row(MINC, MAXC, MINC,   MAXC, MINC, MAXC,   MAXC, MAXC, MINC, F_ACT,    0, 0, 0, 0, 0);
    add_row(MAXC, MINC, 0,      MINC, MAXC, MINC,   0, MINC, MAXC, F_ACT,       0, 1, 0, 0, 0);
    add_row(-1, -1, -1,         1, -1, -1,          -1, 1, -1,     F_ACT,       0, 0, 0, 0, 0);
    add_row(MINC, 0, MAXC,      MAXC, MAXC, MINC,   MINC, MINC, MINC, F_ACT,    0, 1, 0, 0, 0);
    add_row(MAXC, 0, 0,         0, MAXC, 0,         0, 0, MAXC,    F_ACT,       0, 0, 0, 0, 0);
    add_row(MINC, 0, 0,         0, MINC, 0,         0, 0, MINC,    F_ACT,       0, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // camera still at its reset position here
    foreach (dir_rows[k])
      push_tri(dir_rows[k].t,
               dir_rows[k].known ? dir_rows[k].want : facing_verdict(dir_rows[k].t));
    drain();

    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      case (p)
        0: begin cx = CB'(MAXC); cy = CB'(MAXC); cz = CB'(MAXC); end
        1: begin cx = CB'(MINC); cy = CB'(MINC); cz = CB'(MINC); end
        2: begin cx = CB'(MAXC); cy = CB'(MINC); cz = '0; end
        3: begin cx = '0; cy = '0; cz = '0; end
        5: begin
          cx = CB'(int'($urandom_range(8191)) - 4096);
          cy = CB'(int'($urandom_range(8191)) - 4096);
          cz = CB'(int'($urandom_range(8191)) - 4096);
        end
        default: begin cx = CB'($urandom()); cy = CB'($urandom()); cz = CB'($urandom()); end
      endcase
      load_camera(cx, cy, cz, (p == 4) || (p == 6));
      for (k = 0; k < 225; k++) begin
        if (p == 2 && k == 110) drain();
        t = gen_tri();
        push_tri(t, facing_verdict(t));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mis_count == 0) begin
      $display("triangle_backface_cull regression: pass");
    end else begin
      $display("triangle_backface_cull regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tbc_pkg.sv
rtl/tbc_if.sv
rtl/tbc_front.sv
rtl/tbc_fifo.sv
rtl/tbc_back.sv
rtl/triangle_backface_cull.sv
rtl/tbc_checker.sv
tb/sv/tb_top.sv
